[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the interrupt controller RTL.
// Define NO_ASSERTIONS to compile them away.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/core/pvic_pkg.sv]
// ---------------------------------------------------------------------------
// pvic_pkg
// Types, codes and helper functions of the pseudo-VIA interrupt controller.
// ---------------------------------------------------------------------------
package pvic_pkg;

    typedef enum logic [1:0] {
        FLV_BASE   = 2'd0,
        FLV_V8     = 2'd1,
        FLV_SONORA = 2'd2,
        FLV_MSC    = 2'd3
    } t_flavour;

    typedef enum logic [2:0] {
        OP_READ     = 3'd0,
        OP_WRITE    = 3'd1,
        OP_SLOT     = 3'd2,
        OP_SOUND    = 3'd3,
        OP_SCSI_IRQ = 3'd4,
        OP_SCSI_DRQ = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        FWD_NONE   = 3'd0,
        FWD_PORT_A = 3'd1,
        FWD_PORT_B = 3'd2,
        FWD_CONFIG = 3'd3,
        FWD_VIDEO  = 3'd4,
        FWD_MSC    = 3'd5
    } t_fwd;

    // Register offsets after address masking.
    localparam logic [7:0] OFF_PORT_B    = 8'h00;
    localparam logic [7:0] OFF_CONFIG    = 8'h01;
    localparam logic [7:0] OFF_SLOT_FLG  = 8'h02;
    localparam logic [7:0] OFF_MAIN_FLG  = 8'h03;
    localparam logic [7:0] OFF_VIDEO     = 8'h10;
    localparam logic [7:0] OFF_SLOT_EN   = 8'h12;
    localparam logic [7:0] OFF_MAIN_EN   = 8'h13;
    localparam logic [7:0] OFF_MSC_LO    = 8'h20;
    localparam logic [7:0] OFF_MSC_HI    = 8'h2F;

    // Address masks.
    localparam logic [7:0] DEC_NARROW    = 8'h13;
    localparam logic [7:0] DEC_WIDE      = 8'h1F;
    localparam logic [7:0] DEC_FULL      = 8'hFF;

    // Bit masks and reset values.
    localparam logic [7:0] SLOT_FLG_RST  = 8'h7F;
    localparam logic [7:0] MAIN_FLG_RST  = 8'h1B;
    localparam logic [7:0] SLOT_IRQ_MASK = 8'h78;
    localparam logic [7:0] MAIN_IRQ_MASK = 8'h1B;
    localparam logic [7:0] SUMMARY_BIT   = 8'h80;
    localparam logic [7:0] SOUND_BIT     = 8'h10;
    localparam logic [7:0] SCSI_IRQ_BIT  = 8'h08;
    localparam logic [7:0] SCSI_DRQ_BIT  = 8'h01;
    localparam logic [7:0] SLOT_WR_BIT   = 8'h40;
    localparam logic [7:0] VIDEO_RD_MASK = 8'h38;
    localparam logic [7:0] LOW7_MASK     = 8'h7F;
    localparam logic [7:0] QUIRK_WR_VAL  = 8'hFF;
    localparam logic [7:0] QUIRK_EN_VAL  = 8'h1F;

    typedef struct packed {
        t_opcode    opcode;
        logic [9:0] address;
        logic [7:0] write_data;
        logic [7:0] slot_mask;
        logic       line_level;
        logic [7:0] ext_data;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_out;
        t_fwd       forward_target;
        logic [3:0] forward_index;
        logic [7:0] forward_data;
    } t_result;

    typedef struct packed {
        logic [7:0] slot_flags;
        logic [7:0] main_flags;
        logic [7:0] slot_enables;
        logic [7:0] main_enables;
        logic [7:0] video;
        logic       sound_line;
        logic       irq;
    } t_state;

    // Refresh the any-slot bit, the sound bit on level flavours and the summary bit.
    function automatic t_state recompute(t_state s, logic is_base);
        logic [7:0] mf;
        logic [7:0] act;
        mf    = s.main_flags;
        mf[1] = |(~s.slot_flags & SLOT_IRQ_MASK & s.slot_enables);
        if (!is_base) begin
            mf[4] = s.sound_line;
        end
        act = mf & s.main_enables & MAIN_IRQ_MASK;
        if (|act) begin
            mf    = act | SUMMARY_BIT;
            s.irq = 1'b1;
        end else begin
            mf[7] = 1'b0;
            s.irq = 1'b0;
        end
        s.main_flags = mf;
        return s;
    endfunction

    // Bit 7 selects set or clear of the written ones in bits 0 to 6.
    function automatic logic [7:0] selector_write(logic [7:0] cur, logic [7:0] v);
        logic [7:0] bits;
        bits = v & LOW7_MASK;
        return v[7] ? (cur | bits) : (cur & ~bits);
    endfunction

endpackage

[rtl/core/pseudo_via_interrupt_controller.sv]
// ---------------------------------------------------------------------------
// pseudo_via_interrupt_controller
// Each item passes the input register, the execute logic and the result register.
// Throughput: one transfer per cycle unless i_out_stall holds a result;
// one result per item, in item order. The single-pass execute logic sets this rate.
// Reset (synchronous, active low): flavour base, flags 0x7F / 0x1B, enables,
// video and sound line zero, irq low, both stages empty.
// ---------------------------------------------------------------------------
module pseudo_via_interrupt_controller
    import pvic_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,

    // Configuration: flavour select.
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,

    // Item channel.
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_opcode,
    input  logic [9:0] i_address,
    input  logic [7:0] i_write_data,
    input  logic [7:0] i_slot_mask,
    input  logic       i_line_level,
    input  logic [7:0] i_external_read_data,

    // Result channel.
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_data,
    output logic       o_irq_out,
    output logic [2:0] o_forward_target,
    output logic [3:0] o_forward_index,
    output logic [7:0] o_forward_data
);

    // Only write the flavour register while the block is idle; nothing enforces it.
    t_flavour r_flavour;

    t_item    w_in_item;
    t_item    w_stage_item;
    logic     w_stage_valid;
    logic     w_out_free;
    logic     w_fire;
    t_result  w_result;
    logic     r_out_valid;
    logic     n_out_valid;
    t_result  r_out;

    assign w_in_item.opcode     = t_opcode'(i_opcode);
    assign w_in_item.address    = i_address;
    assign w_in_item.write_data = i_write_data;
    assign w_in_item.slot_mask  = i_slot_mask;
    assign w_in_item.line_level = i_line_level;
    assign w_in_item.ext_data   = i_external_read_data;

    // The result register is free when empty or when its transfer completes now,
    // so the pipeline keeps moving one item per cycle under a taken result.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = w_stage_valid && w_out_free;

    pvic_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (w_in_item),
        .i_advance (w_out_free),
        .o_stall   (o_in_stall),
        .o_valid   (w_stage_valid),
        .o_item    (w_stage_item)
    );

    // Register state is updated at the same edge that captures the result.
    pvic_exec u_exec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_flavour (r_flavour),
        .i_item    (w_stage_item),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flavour <= FLV_BASE;
        end else if (i_cfg_we) begin
            r_flavour <= t_flavour'(i_cfg_data);
        end
    end

    always_comb begin
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload only loads on a fire, so a stalled result holds.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_out.read_data;
    assign o_irq_out        = r_out.irq_out;
    assign o_forward_target = r_out.forward_target;
    assign o_forward_index  = r_out.forward_index;
    assign o_forward_data   = r_out.forward_data;

endmodule

[rtl/core/pvic_in_reg.sv]
// ---------------------------------------------------------------------------
// pvic_in_reg
// Input register stage: holds one item until the execute stage takes it.
// ---------------------------------------------------------------------------
module pvic_in_reg
    import pvic_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_stall,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_accept;

    // A held item blocks the input only while it cannot move on.
    assign o_stall  = r_valid && !i_advance;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/core/pvic_exec.sv]
// ---------------------------------------------------------------------------
// pvic_exec
// Controller registers and the single-pass logic that applies one item.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pvic_exec
    import pvic_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_flavour i_flavour,
    input  t_item    i_item,
    output t_result  o_result
);

    t_state     r_state;
    t_state     n_state;
    t_result    w_res;
    logic       w_base;
    logic       w_msc;
    logic [7:0] w_rd_off;
    logic [7:0] w_wr_off;
    logic       w_msc_win;
    logic [7:0] w_wdata;

    assign w_base    = (i_flavour == FLV_BASE);
    assign w_msc     = (i_flavour == FLV_MSC);
    assign w_wdata   = i_item.write_data;
    assign w_msc_win = (i_item.address[7:0] >= OFF_MSC_LO) &&
                       (i_item.address[7:0] <= OFF_MSC_HI);

    // Read and write decode differ for the v8 flavour.
    always_comb begin
        unique case (i_flavour)
            FLV_BASE:   w_rd_off = i_item.address[7:0] & DEC_NARROW;
            FLV_V8:     w_rd_off = i_item.address[7:0] & DEC_NARROW;
            FLV_SONORA: w_rd_off = i_item.address[7:0] & DEC_WIDE;
            FLV_MSC:    w_rd_off = i_item.address[7:0] & DEC_FULL;
            default:    w_rd_off = i_item.address[7:0] & DEC_FULL;
        endcase
        unique case (i_flavour)
            FLV_BASE:   w_wr_off = i_item.address[7:0] & DEC_NARROW;
            FLV_V8:     w_wr_off = i_item.address[7:0] & DEC_WIDE;
            FLV_SONORA: w_wr_off = i_item.address[7:0] & DEC_WIDE;
            FLV_MSC:    w_wr_off = i_item.address[7:0] & DEC_FULL;
            default:    w_wr_off = i_item.address[7:0] & DEC_FULL;
        endcase
    end

    always_comb begin
        n_state = r_state;
        w_res   = '0;
        unique case (i_item.opcode)
            OP_READ: begin
                if (w_msc && w_msc_win) begin
                    w_res.read_data = i_item.ext_data;
                end else if (w_msc && (w_rd_off >= OFF_MSC_LO)) begin
                    w_res.read_data = '0;
                end else begin
                    unique case (w_rd_off)
                        OFF_PORT_B:   w_res.read_data = w_msc ? i_item.ext_data : 8'h00;
                        OFF_CONFIG:   w_res.read_data = i_item.ext_data;
                        OFF_SLOT_FLG: w_res.read_data = r_state.slot_flags;
                        OFF_MAIN_FLG: w_res.read_data = r_state.main_flags;
                        OFF_VIDEO: begin
                            w_res.read_data = (r_state.video & ~VIDEO_RD_MASK) |
                                              i_item.ext_data;
                        end
                        OFF_SLOT_EN:  w_res.read_data = r_state.slot_enables & LOW7_MASK;
                        OFF_MAIN_EN:  w_res.read_data = r_state.main_enables & LOW7_MASK;
                        default:      w_res.read_data = '0;
                    endcase
                end
            end
            OP_WRITE: begin
                if (w_msc && w_msc_win) begin
                    w_res.forward_target = FWD_MSC;
                    w_res.forward_index  = i_item.address[3:0];
                    w_res.forward_data   = w_wdata;
                end else if (!w_msc && i_item.address[9]) begin
                    w_res.forward_target = FWD_PORT_A;
                    w_res.forward_data   = w_wdata;
                end else begin
                    unique case (w_wr_off)
                        OFF_PORT_B: begin
                            w_res.forward_target = FWD_PORT_B;
                            w_res.forward_data   = w_wdata;
                        end
                        OFF_CONFIG: begin
                            w_res.forward_target = FWD_CONFIG;
                            w_res.forward_data   = w_wdata;
                        end
                        OFF_SLOT_FLG: begin
                            n_state.slot_flags = r_state.slot_flags | (w_wdata & SLOT_WR_BIT);
                            n_state = recompute(n_state, w_base);
                        end
                        OFF_MAIN_FLG: begin
                            // Level flavours keep the sound bit; it mirrors the line.
                            n_state.main_flags = r_state.main_flags & ~(w_wdata & LOW7_MASK &
                                                 (w_base ? 8'hFF : ~SOUND_BIT));
                            n_state = recompute(n_state, w_base);
                        end
                        OFF_VIDEO: begin
                            n_state.video        = w_wdata;
                            w_res.forward_target = FWD_VIDEO;
                            w_res.forward_data   = w_wdata;
                        end
                        OFF_SLOT_EN: begin
                            n_state.slot_enables = selector_write(r_state.slot_enables, w_wdata);
                            n_state = recompute(n_state, w_base);
                        end
                        OFF_MAIN_EN: begin
                            n_state.main_enables = selector_write(r_state.main_enables, w_wdata);
                            if (w_base && (w_wdata == QUIRK_WR_VAL)) begin
                                n_state.main_enables = QUIRK_EN_VAL;
                            end
                            n_state = recompute(n_state, w_base);
                        end
                        default: begin
                            n_state = r_state;
                        end
                    endcase
                end
            end
            OP_SLOT: begin
                if (i_item.line_level) begin
                    n_state.slot_flags = r_state.slot_flags & ~i_item.slot_mask;
                end else begin
                    n_state.slot_flags = r_state.slot_flags | i_item.slot_mask;
                end
                n_state = recompute(n_state, w_base);
            end
            OP_SOUND: begin
                n_state.sound_line = i_item.line_level;
                if (w_base) begin
                    // Edge-latched: only a rising edge raises the sound flag.
                    if (i_item.line_level && !r_state.sound_line) begin
                        n_state.main_flags = r_state.main_flags | SOUND_BIT;
                        n_state = recompute(n_state, w_base);
                    end
                end else begin
                    n_state = recompute(n_state, w_base);
                end
            end
            OP_SCSI_IRQ: begin
                n_state.main_flags = i_item.line_level ? (r_state.main_flags | SCSI_IRQ_BIT)
                                                       : (r_state.main_flags & ~SCSI_IRQ_BIT);
                n_state = recompute(n_state, w_base);
            end
            OP_SCSI_DRQ: begin
                n_state.main_flags = i_item.line_level ? (r_state.main_flags | SCSI_DRQ_BIT)
                                                       : (r_state.main_flags & ~SCSI_DRQ_BIT);
                n_state = recompute(n_state, w_base);
            end
            default: begin
                n_state = r_state;
            end
        endcase
        w_res.irq_out = n_state.irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.slot_flags   <= SLOT_FLG_RST;
            r_state.main_flags   <= MAIN_FLG_RST;
            r_state.slot_enables <= '0;
            r_state.main_enables <= '0;
            r_state.video        <= '0;
            r_state.sound_line   <= 1'b0;
            r_state.irq          <= 1'b0;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

    assign o_result = w_res;

    `ASSERT_ALWAYS(a_irq_is_summary, i_clk, i_rst_n, r_state.irq == r_state.main_flags[7], "irq level and summary flag disagree")
    `ASSERT_ALWAYS(a_main_unused_clear, i_clk, i_rst_n, (r_state.main_flags & 8'h64) == 8'h00, "unused main flag bits set")
    `ASSERT_NEXT(a_idle_holds_flags, i_clk, i_rst_n, i_rst_n && !i_fire, $stable(r_state.main_flags) && $stable(r_state.slot_flags), "flags changed without an item")

endmodule

[bench/pseudo_via_interrupt_controller_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pseudo_via_interrupt_controller_tb
// Self-checking bench for the pseudo-VIA interrupt controller. A behavioral
// model of the flag, enable, video and sound-line registers predicts every
// response. A scoreboard compares each response transfer, field by field,
// against the oldest prediction. Directed checks come first, then random
// bus and interrupt-line traffic under every flavour. Both sides of the
// stream are throttled at random.
// ---------------------------------------------------------------------------
module pseudo_via_interrupt_controller_tb
    import pvic_pkg::*;
();

    // The opcode port is three bits wide, so two codes have no operation
    // behind them. The block must answer them with the current irq only.
    localparam logic [2:0] OP_SPARE_A   = 3'd6;
    localparam logic [2:0] OP_SPARE_B   = 3'd7;
    // Main flag bit that summarizes the enabled slot interrupts.
    localparam logic [7:0] ANY_SLOT_BIT = 8'h02;

    // One bus access or line event, as it is presented on the input ports.
    typedef struct packed {
        logic [2:0] op;
        logic [9:0] address;
        logic [7:0] write_data;
        logic [7:0] slot_mask;
        logic       line_level;
        logic [7:0] ext_data;
    } pvic_txn;

    // Clock, reset and all block inputs hold known values from time zero.
    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_we     = 1'b0;
    logic [1:0] cfg_data   = '0;
    logic       in_valid   = 1'b0;
    logic [2:0] opcode     = '0;
    logic [9:0] address    = '0;
    logic [7:0] write_data = '0;
    logic [7:0] slot_mask  = '0;
    logic       line_level = 1'b0;
    logic [7:0] ext_data   = '0;
    logic       out_stall  = 1'b0;

    logic       in_stall;
    logic       out_valid;
    logic [7:0] read_data;
    logic       irq_out;
    logic [2:0] fwd_target;
    logic [3:0] fwd_index;
    logic [7:0] fwd_data;

    // Model state. It tracks the block from reset and follows every flavour
    // write, so it must never be touched except by an accepted transfer.
    t_flavour   flv       = FLV_BASE;
    logic [7:0] slot_flg  = SLOT_FLG_RST;
    logic [7:0] main_flg  = MAIN_FLG_RST;
    logic [7:0] slot_en   = 8'h00;
    logic [7:0] main_en   = 8'h00;
    logic [7:0] video_r   = 8'h00;
    logic       sound_lvl = 1'b0;
    logic       irq_lvl   = 1'b0;

    // Responses predicted for accepted items, oldest first.
    t_result    pending_responses [$];
    t_result    oldest_response;

    // Throttling switches, changed per test so that some phases run flat out.
    bit         src_idle_on  = 1'b1;
    bit         sink_idle_on = 1'b1;

    int unsigned error_count       = 0;
    int unsigned transfers_in      = 0;
    int unsigned responses_checked = 0;
    int unsigned irq_responses     = 0;
    int unsigned forwarded_writes  = 0;

    always #4 clk = ~clk;

    pseudo_via_interrupt_controller dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_we             (cfg_we),
        .i_cfg_data           (cfg_data),
        .i_in_valid           (in_valid),
        .o_in_stall           (in_stall),
        .i_opcode             (opcode),
        .i_address            (address),
        .i_write_data         (write_data),
        .i_slot_mask          (slot_mask),
        .i_line_level         (line_level),
        .i_external_read_data (ext_data),
        .o_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .o_read_data          (read_data),
        .o_irq_out            (irq_out),
        .o_forward_target     (fwd_target),
        .o_forward_index      (fwd_index),
        .o_forward_data       (fwd_data)
    );

    // -----------------------------------------------------------------------
    // Behavioral model of the controller.
    // -----------------------------------------------------------------------

    // Rebuilds the any-slot bit, mirrors the sound level on the level
    // flavours, and then either collapses the main flags to the active
    // sources plus the summary bit or drops the summary bit.
    function automatic void refresh_summary();
        logic [7:0] raised;
        if ((~slot_flg & SLOT_IRQ_MASK & slot_en) != 8'h00) main_flg |= ANY_SLOT_BIT;
        else main_flg &= ~ANY_SLOT_BIT;
        if (flv != FLV_BASE) begin
            main_flg = sound_lvl ? (main_flg | SOUND_BIT) : (main_flg & ~SOUND_BIT);
        end
        raised   = main_flg & main_en & MAIN_IRQ_MASK;
        irq_lvl  = (raised != 8'h00);
        main_flg = irq_lvl ? (raised | SUMMARY_BIT) : (main_flg & LOW7_MASK);
    endfunction

    // Enable registers: bit 7 of the written byte chooses between setting
    // and clearing the ones written in bits 0 to 6.
    function automatic logic [7:0] apply_set_clear(logic [7:0] cur, logic [7:0] v);
        return v[7] ? (cur | (v & LOW7_MASK)) : (cur & ~(v & LOW7_MASK));
    endfunction

    // Byte returned by a read. Reads never change state.
    function automatic logic [7:0] via_read_byte(logic [9:0] addr, logic [7:0] ext);
        logic [7:0] off;
        off = addr[7:0] & ((flv == FLV_MSC) ? DEC_FULL :
                           (flv == FLV_SONORA) ? DEC_WIDE : DEC_NARROW);
        // The msc window is external; everything above it reads as zero.
        if (flv == FLV_MSC && off >= OFF_MSC_LO) return (off <= OFF_MSC_HI) ? ext : 8'h00;
        case (off)
            OFF_PORT_B:   return (flv == FLV_MSC) ? ext : 8'h00;
            OFF_CONFIG:   return ext;
            OFF_SLOT_FLG: return slot_flg;
            OFF_MAIN_FLG: return main_flg;
            OFF_VIDEO:    return (video_r & ~VIDEO_RD_MASK) | ext;
            OFF_SLOT_EN:  return slot_en & LOW7_MASK;
            OFF_MAIN_EN:  return main_en & LOW7_MASK;
            default:      return 8'h00;
        endcase
    endfunction

    // State update and forwarded transfer caused by a write.
    function automatic t_result via_write_effect(logic [9:0] addr, logic [7:0] wd);
        t_result    r;
        logic [7:0] off;
        logic [7:0] clr;
        r   = '0;
        off = addr[7:0] & ((flv == FLV_MSC) ? DEC_FULL :
                           (flv == FLV_BASE) ? DEC_NARROW : DEC_WIDE);
        if (flv == FLV_MSC && off >= OFF_MSC_LO && off <= OFF_MSC_HI) begin
            r.forward_target = FWD_MSC;
            r.forward_index  = off[3:0];
            r.forward_data   = wd;
        end else if (flv != FLV_MSC && addr[9]) begin
            // The upper half of the address space belongs to port A.
            r.forward_target = FWD_PORT_A;
            r.forward_data   = wd;
        end else begin
            case (off)
                OFF_PORT_B: begin
                    r.forward_target = FWD_PORT_B;
                    r.forward_data   = wd;
                end
                OFF_CONFIG: begin
                    r.forward_target = FWD_CONFIG;
                    r.forward_data   = wd;
                end
                OFF_SLOT_FLG: begin
                    slot_flg |= wd & SLOT_WR_BIT;
                    refresh_summary();
                end
                OFF_MAIN_FLG: begin
                    // Level flavours own the sound bit; software cannot clear it.
                    clr = wd & LOW7_MASK;
                    if (flv != FLV_BASE) clr &= ~SOUND_BIT;
                    main_flg &= ~clr;
                    refresh_summary();
                end
                OFF_VIDEO: begin
                    video_r          = wd;
                    r.forward_target = FWD_VIDEO;
                    r.forward_data   = wd;
                end
                OFF_SLOT_EN: begin
                    slot_en = apply_set_clear(slot_en, wd);
                    refresh_summary();
                end
                OFF_MAIN_EN: begin
                    // On the base flavour a set-all write keeps only the five
                    // low enable bits.
                    main_en = (flv == FLV_BASE && wd == QUIRK_WR_VAL) ?
                              QUIRK_EN_VAL : apply_set_clear(main_en, wd);
                    refresh_summary();
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // Response that one accepted item produces, with the model updated.
    function automatic t_result via_step_response(pvic_txn t);
        t_result r;
        r = '0;
        case (t.op)
            OP_READ:  r.read_data = via_read_byte(t.address, t.ext_data);
            OP_WRITE: r = via_write_effect(t.address, t.write_data);
            OP_SLOT: begin
                // Slot flags are active low: an asserted line clears its bits.
                slot_flg = t.line_level ? (slot_flg & ~t.slot_mask) : (slot_flg | t.slot_mask);
                refresh_summary();
            end
            OP_SOUND: begin
                if (flv == FLV_BASE) begin
                    // Edge-latched: only a rising edge sets the flag.
                    if (t.line_level && !sound_lvl) begin
                        main_flg |= SOUND_BIT;
                        refresh_summary();
                    end
                    sound_lvl = t.line_level;
                end else begin
                    sound_lvl = t.line_level;
                    refresh_summary();
                end
            end
            OP_SCSI_IRQ: begin
                main_flg = t.line_level ? (main_flg | SCSI_IRQ_BIT) : (main_flg & ~SCSI_IRQ_BIT);
                refresh_summary();
            end
            OP_SCSI_DRQ: begin
                main_flg = t.line_level ? (main_flg | SCSI_DRQ_BIT) : (main_flg & ~SCSI_DRQ_BIT);
                refresh_summary();
            end
            default: ;
        endcase
        r.irq_out = irq_lvl;
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Stream drivers.
    // -----------------------------------------------------------------------

    // Presents one item after a random gap and holds it until the block
    // takes it. All drive happens on the falling edge; the handshake is
    // sampled on the rising edge. Valid is left high on return so that a
    // back-to-back item never lowers and raises it in the same step.
    task automatic send_item(input pvic_txn t);
        int unsigned gap;
        gap = src_idle_on ? $urandom_range(0, 15) : 0;
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= t.op;
        address    <= t.address;
        write_data <= t.write_data;
        slot_mask  <= t.slot_mask;
        line_level <= t.line_level;
        ext_data   <= t.ext_data;
        do @(posedge clk); while (in_stall !== 1'b0);
        pending_responses.push_back(via_step_response(t));
        transfers_in++;
    endtask

    // Drops valid and waits until every predicted response has come back.
    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge clk);
    endtask

    // The flavour register may only change while the block is idle. The
    // pipeline is two stages deep, so the extra wait after the last
    // response is plenty.
    task automatic set_flavour(input t_flavour f);
        hold_until_drained();
        repeat (4) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= f;
        @(negedge clk);
        cfg_we   <= 1'b0;
        flv       = f;
    endtask

    // Random item. Most of them are accesses to decoded registers with
    // noise in the address bits that the decode ignores, or line events,
    // so that enables, flags and the summary interrupt keep moving.
    function automatic pvic_txn random_item();
        pvic_txn     t;
        int unsigned pick;
        logic [7:0]  dec;
        logic [7:0]  off;
        t.address    = 10'($urandom_range(0, 1023));
        t.write_data = 8'($urandom_range(0, 255));
        t.slot_mask  = 8'($urandom_range(0, 255));
        t.line_level = 1'($urandom_range(0, 1));
        t.ext_data   = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 20) t.op = OP_READ;
        else if (pick < 48) t.op = OP_WRITE;
        else if (pick < 97) t.op = 3'($urandom_range(OP_SLOT, OP_SCSI_DRQ));
        else t.op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_B));
        if ((t.op == OP_READ || t.op == OP_WRITE) && $urandom_range(0, 3) != 0) begin
            if (flv == FLV_MSC) dec = DEC_FULL;
            else if (t.op == OP_WRITE) dec = (flv == FLV_BASE) ? DEC_NARROW : DEC_WIDE;
            else dec = (flv == FLV_SONORA) ? DEC_WIDE : DEC_NARROW;
            case ($urandom_range(0, 7))
                0:       off = OFF_PORT_B;
                1:       off = OFF_CONFIG;
                2:       off = OFF_SLOT_FLG;
                3:       off = OFF_MAIN_FLG;
                4:       off = OFF_VIDEO;
                5:       off = OFF_SLOT_EN;
                6:       off = OFF_MAIN_EN;
                default: off = OFF_MSC_LO | 8'($urandom_range(0, 15));
            endcase
            t.address[7:0] = (t.address[7:0] & ~dec) | off;
            // Keep most writes out of the port A half.
            if (t.op == OP_WRITE && $urandom_range(0, 3) != 0) t.address[9] = 1'b0;
        end
        return t;
    endfunction

    // Response side: before each response it may hold stall high for a
    // random number of cycles, then it takes exactly one transfer.
    initial begin : response_sink
        int unsigned hold;
        wait (rst_n === 1'b1);
        forever begin
            hold = sink_idle_on ? $urandom_range(0, 15) : 0;
            @(negedge clk);
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid === 1'b1 && out_stall == 1'b0));
        end
    end

    // -----------------------------------------------------------------------
    // Scoreboard.
    // -----------------------------------------------------------------------

    function automatic void compare_field(input string what, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h", $time, what, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
            responses_checked++;
            if (irq_out === 1'b1) irq_responses++;
            if (fwd_target != FWD_NONE) forwarded_writes++;
            if (pending_responses.size() == 0) begin
                $display("%0t: response with nothing expected, actual rd 0x%02h irq %b fwd %0d",
                         $time, read_data, irq_out, fwd_target);
                error_count++;
            end else begin
                oldest_response = pending_responses.pop_front();
                compare_field("read_data", oldest_response.read_data, read_data);
                compare_field("irq_out", {7'b0, oldest_response.irq_out}, {7'b0, irq_out});
                compare_field("forward_target", {5'b0, oldest_response.forward_target},
                              {5'b0, fwd_target});
                compare_field("forward_index", {4'b0, oldest_response.forward_index},
                              {4'b0, fwd_index});
                compare_field("forward_data", oldest_response.forward_data, fwd_data);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Tests.
    // -----------------------------------------------------------------------

    // Base flavour from reset: reset values, the set-all enable quirk, the
    // edge-latched sound flag, port A forwarding, the video read mask,
    // address extremes and the two opcodes with no operation.
    task automatic test_reset_and_base_quirks();
        set_flavour(FLV_BASE);
        send_item('{OP_READ,     10'h003, 8'h00, 8'h00, 1'b0, 8'hFF});
        send_item('{OP_READ,     10'h002, 8'h00, 8'h00, 1'b0, 8'h00});
        send_item('{OP_WRITE,    10'h013, 8'hFF, 8'h00, 1'b0, 8'h00});
        send_item('{OP_SOUND,    10'h000, 8'h00, 8'h00, 1'b1, 8'h00});
        // A held line must not set the flag a second time.
        send_item('{OP_SOUND,    10'h000, 8'h00, 8'h00, 1'b1, 8'h00});
        send_item('{OP_WRITE,    10'h003, 8'hFF, 8'h00, 1'b0, 8'h00});
        send_item('{OP_READ,     10'h3FF, 8'h00, 8'h00, 1'b0, 8'hFF});
        send_item('{OP_WRITE,    10'h3FF, 8'h00, 8'h00, 1'b0, 8'h00});
        send_item('{OP_WRITE,    10'h010, 8'hFF, 8'h00, 1'b0, 8'h00});
        send_item('{OP_READ,     10'h010, 8'h00, 8'h00, 1'b0, 8'h00});
        send_item('{OP_SPARE_A,  10'h3FF, 8'hFF, 8'hFF, 1'b1, 8'hFF});
        send_item('{OP_SPARE_B,  10'h3FF, 8'hFF, 8'hFF, 1'b1, 8'hFF});
    endtask

    // Level flavours: slot interrupts, the slot flag write, the sound bit
    // that software cannot clear, SCSI lines, and the msc register window
    // with its full address decode.
    task automatic test_level_flavours();
        set_flavour(FLV_SONORA);
        send_item('{OP_WRITE,    10'h012, 8'hF8, 8'h00, 1'b0, 8'h00});
        send_item('{OP_SLOT,     10'h000, 8'h00, 8'hFF, 1'b1, 8'h00});
        send_item('{OP_WRITE,    10'h002, 8'hFF, 8'h00, 1'b0, 8'h00});
        send_item('{OP_SOUND,    10'h000, 8'h00, 8'h00, 1'b1, 8'h00});
        send_item('{OP_WRITE,    10'h003, 8'hFF, 8'h00, 1'b0, 8'h00});
        send_item('{OP_SCSI_IRQ, 10'h000, 8'h00, 8'h00, 1'b1, 8'h00});
        send_item('{OP_SCSI_DRQ, 10'h000, 8'h00, 8'h00, 1'b0, 8'h00});
        send_item('{OP_READ,     10'h01F, 8'h00, 8'h00, 1'b0, 8'hFF});
        set_flavour(FLV_MSC);
        send_item('{OP_WRITE,    10'h02F, 8'hA5, 8'h00, 1'b0, 8'h00});
        send_item('{OP_READ,     10'h020, 8'h00, 8'h00, 1'b0, 8'h5A});
        send_item('{OP_READ,     10'h000, 8'h00, 8'h00, 1'b0, 8'hC3});
        send_item('{OP_READ,     10'h0FF, 8'h00, 8'h00, 1'b0, 8'hFF});
        // Msc ignores the port A half: this lands on port B.
        send_item('{OP_WRITE,    10'h300, 8'h81, 8'h00, 1'b0, 8'h00});
    endtask

    // Random traffic under one flavour. Midway, and now and then at random,
    // the sender stops until every response is back.
    task automatic test_random_traffic(input t_flavour f, input int unsigned count,
                                       input bit src_gaps, input bit sink_gaps);
        set_flavour(f);
        src_idle_on  = src_gaps;
        sink_idle_on = sink_gaps;
        for (int unsigned n = 0; n < count; n++) begin
            if (n == count / 2 || $urandom_range(0, 63) == 0) hold_until_drained();
            send_item(random_item());
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_and_base_quirks();
        test_level_flavours();
        test_random_traffic(FLV_BASE,   160, 1'b1, 1'b1);
        test_random_traffic(FLV_V8,     160, 1'b0, 1'b0);
        test_random_traffic(FLV_SONORA, 160, 1'b1, 1'b0);
        test_random_traffic(FLV_MSC,    160, 1'b0, 1'b1);

        hold_until_drained();
        repeat (8) @(posedge clk);

        $display("Run covered %0d item transfers and %0d response transfers over all flavours.",
                 transfers_in, responses_checked);
        $display("%0d responses carried a raised interrupt and %0d a forwarded write.",
                 irq_responses, forwarded_writes);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: the slowest legal run needs well under a quarter of this.
    initial begin
        #2_000_000;
        $display("Run stopped by the watchdog with %0d responses outstanding.",
                 pending_responses.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

[pseudo_via_interrupt_controller.f]
+incdir+rtl/core
rtl/core/pvic_pkg.sv
rtl/core/pvic_in_reg.sv
rtl/core/pvic_exec.sv
rtl/core/pseudo_via_interrupt_controller.sv
bench/pseudo_via_interrupt_controller_tb.sv
